// ----- sv/tilted_dipole_field_eval_top_assert.svh -----
// assertion macros for the dipole field evaluator checker
`ifndef TILTED_DIPOLE_FIELD_EVAL_TOP_ASSERT_SVH
`define TILTED_DIPOLE_FIELD_EVAL_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TDFE_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define TDFE_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tdfe_pkg.sv -----
// shared types, widths and register codes of the dipole field evaluator
`timescale 1ns / 1ps
`default_nettype none
package tdfe_pkg;

  localparam int POS_W      = 32;
  localparam int FLD_W      = 32;
  localparam int MOM_W      = 32;
  localparam int STR_W      = 63;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOM_X    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOM_Y    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOM_Z    = 8'd3;

  localparam logic [MOM_W-1:0] MOM_Z_RST = 32'h4000_0000;
  localparam logic [FLD_W-1:0] FLD_MAX   = 32'h7fff_ffff;
  localparam logic [FLD_W-1:0] FLD_MIN   = 32'h8000_0000;

  // derived widths
  localparam int SW      = 2 * POS_W;
  localparam int DMW     = POS_W + MOM_W;
  localparam int DSW     = DMW + 1;
  localparam int NW      = 2 * POS_W + 34;
  localparam int NSW     = NW + 1;
  localparam int RQ_SH   = 32;
  localparam int RQW     = (SW + RQ_SH) / 2;
  localparam int RQSW    = SW + RQW;
  localparam int DENW    = RQSW + SW;
  localparam int NUMW    = STR_W + NW;
  localparam int FRAC_SH = 16;

  // multiplier digit sizes
  localparam int MUL_K = 2;
  localparam int PDG   = (POS_W + MUL_K - 1) / MUL_K;
  localparam int MDG   = (MOM_W + MUL_K - 1) / MUL_K;
  localparam int RQDG  = 16;
  localparam int SDG   = 8;
  localparam int KDG   = 8;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic signed [FLD_W-1:0] field_x;
    logic signed [FLD_W-1:0] field_y;
    logic signed [FLD_W-1:0] field_z;
    logic                    inside_res;
    logic                    saturated;
  } field_t;

endpackage
`default_nettype wire

// ----- sv/tdfe_pmul.sv -----
// pipelined unsigned multiplier, one digit of b per stage
`timescale 1ns / 1ps
`default_nettype none
module tdfe_pmul #(
  parameter int WA = 8,
  parameter int WB = 8,
  parameter int DG = 4
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WA-1:0]    a,
  input  wire logic [WB-1:0]    b,
  output logic      [WA+WB-1:0] p
);

  localparam int K  = (WB + DG - 1) / DG;
  localparam int BW = K * DG;
  localparam int PW = WA + BW;

  logic [WA-1:0] a_q   [K];
  logic [BW-1:0] b_q   [K];
  logic [PW-1:0] acc_q [K];

  for (genvar j = 0; j < K; j++) begin : g_stg
    logic [WA-1:0]    a_in;
    logic [BW-1:0]    b_in;
    logic [PW-1:0]    acc_in;
    logic [WA+DG-1:0] pp;

    if (j == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BW'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[j-1];
      assign b_in   = b_q[j-1];
      assign acc_in = acc_q[j-1];
    end

    assign pp = (WA+DG)'(a_in) * (WA+DG)'(b_in[DG-1:0]);

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[j]   <= a_in;
        b_q[j]   <= b_in >> DG;
        acc_q[j] <= acc_in + (PW'(pp) << (DG * j));
      end
    end
  end

  assign p = acc_q[K-1][WA+WB-1:0];

endmodule
`default_nettype wire

// ----- sv/tdfe_dly.sv -----
// enabled delay line for side data that rides along the pipeline
`timescale 1ns / 1ps
`default_nettype none
module tdfe_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule
`default_nettype wire

// ----- sv/tdfe_isqrt.sv -----
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tdfe_isqrt #(
  parameter int W = 8
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*W-1:0] x,
  output logic      [W-1:0]   root
);

  localparam int RW = W + 2;

  logic [RW-1:0]  rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] x_q    [W];

  for (genvar j = 0; j < W; j++) begin : g_stg
    logic [RW-1:0]  rem_in;
    logic [W-1:0]   root_in;
    logic [2*W-1:0] x_in;
    logic [RW+1:0]  tr;
    logic [RW+1:0]  trial;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign x_in    = x_q[j-1];
    end

    assign tr    = {rem_in, x_in[2*W-1:2*W-2]};
    assign trial = (RW+2)'({root_in, 2'b01});
    assign ge    = tr >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= ge ? RW'(tr - trial) : RW'(tr);
        root_q[j] <= {root_in[W-2:0], ge};
        x_q[j]    <= x_in << 2;
      end
    end
  end

  assign root = root_q[W-1];

endmodule
`default_nettype wire

// ----- sv/tdfe_div.sv -----
// pipelined restoring divider with overflow detect and signed clamp
`timescale 1ns / 1ps
`default_nettype none
module tdfe_div #(
  parameter int NUMW = 8,
  parameter int DENW = 8
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [NUMW-1:0]           num,
  input  wire logic [DENW-1:0]           den,
  input  wire logic                      neg,
  output logic      [tdfe_pkg::FLD_W-1:0] fld,
  output logic                           sat
);

  import tdfe_pkg::*;

  localparam int QW = FLD_W;
  localparam int XW = NUMW + FRAC_SH;
  localparam int HW = XW - QW;
  localparam int CW = (HW > DENW) ? HW : DENW;
  localparam int RW = DENW + 1;

  logic [XW-1:0]   x;
  logic [RW-1:0]   rem_q [QW+1];
  logic [QW-1:0]   lo_q  [QW+1];
  logic [QW-1:0]   q_q   [QW+1];
  logic [DENW-1:0] den_q [QW+1];
  logic            neg_q [QW+1];
  logic            ovf_q [QW+1];
  logic            over;
  logic [QW-1:0]   qf;

  assign x = {num, {FRAC_SH{1'b0}}};

  // quotient of 2^QW or more never fits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= RW'(x[XW-1:QW]);
      lo_q[0]  <= x[QW-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den;
      neg_q[0] <= neg;
      ovf_q[0] <= CW'(x[XW-1:QW]) >= CW'(den);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stg
    logic [RW:0] tr;
    logic [RW:0] dv;
    logic        ge;

    assign tr = {rem_q[j-1], lo_q[j-1][QW-1]};
    assign dv = (RW+1)'(den_q[j-1]);
    assign ge = tr >= dv;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? RW'(tr - dv) : RW'(tr);
        lo_q[j]  <= lo_q[j-1] << 1;
        q_q[j]   <= {q_q[j-1][QW-2:0], ge};
        den_q[j] <= den_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign qf   = q_q[QW];
  assign over = ovf_q[QW] | (neg_q[QW] ? (qf > FLD_MIN) : qf[QW-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (over) begin
        fld <= neg_q[QW] ? FLD_MIN : FLD_MAX;
      end else begin
        fld <= neg_q[QW] ? (~qf + 1'b1) : qf;
      end
      sat <= over;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tilted_dipole_field_eval_top.sv -----
// Tilted dipole field evaluator, fully pipelined.
//
// Input channel pos_valid/pos_stall/pos carries one position beat (signed metres).
// Output channel field_valid/field_stall/field carries the field beat (signed nT)
// with the inside_res and saturated flags. A beat moves on an edge where valid
// is high and stall is low.
// Config port cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 dipole strength,
// 1..3 moment x, y, z in Q1.30; other indexes are ignored. cfg_ready is always high.
// Throughput: one beat per cycle unless a stalled output beat holds the pipeline. A beat
// passes through the 48-stage square root, the denominator multipliers and the
// 34-stage divider in series.
// The whole pipeline advances together; while field_valid is high and
// field_stall is high every stage holds and pos_stall is raised.
// Synchronous reset empties the pipeline and loads strength 0 and moment (0, 0, 1).
`timescale 1ns / 1ps
`default_nettype none
module tilted_dipole_field_eval_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           pos_valid,
  output logic                                pos_stall,
  input  wire tdfe_pkg::pos_t                 pos,
  output logic                                field_valid,
  input  wire logic                           field_stall,
  output tdfe_pkg::field_t                    field,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tdfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tdfe_pkg::CFG_DATA_W-1:0] cfg_data
);

  import tdfe_pkg::*;

  localparam int K_P   = (POS_W + PDG - 1) / PDG;
  localparam int K_K   = (STR_W + KDG - 1) / KDG;
  localparam int K_RQS = (RQW + RQDG - 1) / RQDG;
  localparam int K_DEN = (SW + SDG - 1) / SDG;
  localparam int T_S   = K_P + 1;
  localparam int T_N   = T_S + K_P + 1;
  localparam int T_KN  = T_N + K_K;
  localparam int T_RQ  = T_S + RQW;
  localparam int T_RQS = T_RQ + K_RQS;
  localparam int T_DEN = T_RQS + K_DEN;
  localparam int T_DIV = T_DEN + FLD_W + 2;
  localparam int T_OUT = T_DIV + 1;

  logic                en;
  logic [T_OUT:0]      vld;

  logic [STR_W-1:0]    strength;
  logic [MOM_W-1:0]    mom   [3];
  logic [MOM_W-1:0]    mabs  [3];
  logic                mneg  [3];

  logic [POS_W-1:0]    pin   [3];
  logic [POS_W-1:0]    pa    [3];
  logic                pn    [3];
  logic [POS_W-1:0]    pa_d  [3];
  logic                pn_d  [3];
  logic [POS_W-1:0]    pa_s  [3];
  logic                pn_s  [3];
  logic [SW-1:0]       sq    [3];
  logic [DMW-1:0]      mp    [3];
  logic [DSW-1:0]      term  [3];

  logic [SW-1:0]       s;
  logic [DSW-1:0]      d;
  logic [DMW-1:0]      dabs;
  logic [RQW-1:0]      rq;
  logic [SW-1:0]       s_d1;
  logic [SW-1:0]       s_d2;
  logic [RQSW-1:0]     rqs;
  logic [DENW-1:0]     den;
  logic                at_center;

  logic [2*POS_W+MOM_W-1:0] dp  [3];
  logic [SW+MOM_W-1:0]      ms  [3];
  logic                     dpn [3];
  logic [NSW-1:0]           n   [3];
  logic [NW-1:0]            nabs [3];
  logic [NUMW-1:0]          kn  [3];
  logic [NUMW-1:0]          kn_d [3];
  logic                     nneg [3];
  logic [FLD_W-1:0]         fld [3];
  logic                     sat [3];

  assign en          = !(field_valid && field_stall);
  assign pos_stall   = !en;
  assign field_valid = vld[T_OUT];
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= '0;
      mom[0]   <= '0;
      mom[1]   <= '0;
      mom[2]   <= MOM_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STRENGTH: strength <= cfg_data[STR_W-1:0];
        REG_MOM_X:    mom[0]   <= cfg_data[MOM_W-1:0];
        REG_MOM_Y:    mom[1]   <= cfg_data[MOM_W-1:0];
        REG_MOM_Z:    mom[2]   <= cfg_data[MOM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T_OUT-1:0], pos_valid};
    end
  end

  assign pin[0] = pos.pos_x;
  assign pin[1] = pos.pos_y;
  assign pin[2] = pos.pos_z;

  // sum of squares and dot product
  always_ff @(posedge clk) begin
    if (en) begin
      s <= sq[0] + sq[1] + sq[2];
      d <= term[0] + term[1] + term[2];
      for (int i = 0; i < 3; i++) begin
        pa_s[i] <= pa_d[i];
        pn_s[i] <= pn_d[i];
      end
    end
  end

  assign dabs = d[DSW-1] ? DMW'(~d + 1'b1) : DMW'(d);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [NSW-1:0] t3;
    logic [NSW-1:0] tt;
    logic [NSW-1:0] uu;
    logic [DSW-1:0] mpx;

    assign mneg[i] = mom[i][MOM_W-1];
    assign mabs[i] = mneg[i] ? (~mom[i] + 1'b1) : mom[i];

    always_ff @(posedge clk) begin
      if (en) begin
        pa[i] <= pin[i][POS_W-1] ? (~pin[i] + 1'b1) : pin[i];
        pn[i] <= pin[i][POS_W-1];
      end
    end

    tdfe_dly #(.W(POS_W), .N(K_P)) u_pa_dly (.clk, .en, .d(pa[i]), .q(pa_d[i]));
    tdfe_dly #(.W(1), .N(K_P)) u_pn_dly (.clk, .en, .d(pn[i]), .q(pn_d[i]));

    tdfe_pmul #(.WA(POS_W), .WB(POS_W), .DG(PDG)) u_sq (
      .clk, .en, .a(pa[i]), .b(pa[i]), .p(sq[i])
    );
    tdfe_pmul #(.WA(MOM_W), .WB(POS_W), .DG(PDG)) u_mp (
      .clk, .en, .a(mabs[i]), .b(pa[i]), .p(mp[i])
    );

    assign mpx     = DSW'(mp[i]);
    assign term[i] = (pn_d[i] ^ mneg[i]) ? (~mpx + 1'b1) : mpx;

    tdfe_pmul #(.WA(DMW), .WB(POS_W), .DG(PDG)) u_dp (
      .clk, .en, .a(dabs), .b(pa_s[i]), .p(dp[i])
    );
    tdfe_pmul #(.WA(SW), .WB(MOM_W), .DG(MDG)) u_ms (
      .clk, .en, .a(s), .b(mabs[i]), .p(ms[i])
    );
    tdfe_dly #(.W(1), .N(K_P)) u_dpn_dly (
      .clk, .en, .d(d[DSW-1] ^ pn_s[i]), .q(dpn[i])
    );

    // n = 3 d p - m s
    assign t3 = NSW'(dp[i]) + (NSW'(dp[i]) << 1);
    assign tt = dpn[i] ? (~t3 + 1'b1) : t3;
    assign uu = mneg[i] ? NSW'(ms[i]) : (~NSW'(ms[i]) + 1'b1);

    always_ff @(posedge clk) begin
      if (en) begin
        n[i] <= tt + uu;
      end
    end

    assign nabs[i] = n[i][NSW-1] ? NW'(~n[i] + 1'b1) : NW'(n[i]);

    tdfe_pmul #(.WA(NW), .WB(STR_W), .DG(KDG)) u_kn (
      .clk, .en, .a(nabs[i]), .b(strength), .p(kn[i])
    );
    tdfe_dly #(.W(NUMW), .N(T_DEN - T_KN)) u_kn_dly (
      .clk, .en, .d(kn[i]), .q(kn_d[i])
    );
    tdfe_dly #(.W(1), .N(T_DEN - T_N)) u_nneg_dly (
      .clk, .en, .d(n[i][NSW-1]), .q(nneg[i])
    );

    tdfe_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
      .clk, .en, .num(kn_d[i]), .den(den), .neg(nneg[i]), .fld(fld[i]), .sat(sat[i])
    );
  end

  // denominator rq * s * s
  tdfe_isqrt #(.W(RQW)) u_isqrt (
    .clk, .en, .x({s, {RQ_SH{1'b0}}}), .root(rq)
  );
  tdfe_dly #(.W(SW), .N(RQW)) u_s_dly1 (.clk, .en, .d(s), .q(s_d1));
  tdfe_dly #(.W(SW), .N(K_RQS)) u_s_dly2 (.clk, .en, .d(s_d1), .q(s_d2));
  tdfe_pmul #(.WA(SW), .WB(RQW), .DG(RQDG)) u_rqs (
    .clk, .en, .a(s_d1), .b(rq), .p(rqs)
  );
  tdfe_pmul #(.WA(RQSW), .WB(SW), .DG(SDG)) u_den (
    .clk, .en, .a(rqs), .b(s_d2), .p(den)
  );
  tdfe_dly #(.W(1), .N(T_DIV - T_S)) u_in_dly (
    .clk, .en, .d(s == '0), .q(at_center)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      field.field_x    <= at_center ? '0 : fld[0];
      field.field_y    <= at_center ? '0 : fld[1];
      field.field_z    <= at_center ? '0 : fld[2];
      field.inside_res <= at_center;
      field.saturated  <= !at_center && (sat[0] || sat[1] || sat[2]);
    end
  end

endmodule
`default_nettype wire

// ----- sv/tdfe_chk.sv -----
// port-level checker for the dipole field evaluator and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "tilted_dipole_field_eval_top_assert.svh"
module tdfe_chk (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pos_valid,
  input wire logic             pos_stall,
  input wire logic             field_valid,
  input wire logic             field_stall,
  input wire tdfe_pkg::field_t field
);

  import tdfe_pkg::*;

  `TDFE_AST_IMP(a_stall_src, pos_stall, field_valid && field_stall, "input stalled without output stall")
  `TDFE_AST_IMP(a_inside_zero, field_valid && field.inside_res, field.field_x == '0 && field.field_y == '0 && field.field_z == '0 && !field.saturated, "inside beat not zeroed")
  `TDFE_AST_IMP(a_sat_limit, field_valid && field.saturated, field.field_x == FLD_MAX || field.field_x == FLD_MIN || field.field_y == FLD_MAX || field.field_y == FLD_MIN || field.field_z == FLD_MAX || field.field_z == FLD_MIN, "saturated beat without clamped value")
  `TDFE_AST_NXT(a_out_hold, field_valid && field_stall, field_valid && $stable(field), "stalled output beat changed")

endmodule

bind tilted_dipole_field_eval_top tdfe_chk u_chk (.*);
`default_nettype wire
